// ----- rtl/kcc_pkg.sv -----
// Shared types, constants and helpers for the key click classifier.
`default_nettype none

package kcc_pkg;

  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] COUNT_MAX = '1;
  localparam logic [CountW-1:0] WINDOW_RESET = 16'd100;

  typedef logic [CountW-1:0] count_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_DOUBLE = 2'd2
  } click_kind_t;

  typedef struct packed {
    logic       press_latch;
    logic       edge_taken;
    logic [1:0] pending_clicks;
    count_t     gap_ticks;
    count_t     hold_ticks;
  } click_state_t;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == COUNT_MAX) ? v : count_t'(v + 1'b1);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/kcc_if.sv -----
// Valid/ready channel interfaces for button samples and click results.
`default_nettype none

interface kcc_in_if;
  logic valid;
  logic ready;
  logic key_pressed;

  modport source (output valid, output key_pressed, input ready);
  modport sink (input valid, input key_pressed, output ready);
endinterface

interface kcc_out_if;
  logic                valid;
  logic                ready;
  kcc_pkg::click_kind_t click_kind;

  modport source (output valid, output click_kind, input ready);
  modport sink (input valid, input click_kind, output ready);
endinterface

`default_nettype wire

// ----- rtl/kcc_step.sv -----
// One-tick update of the click classifier state and its classification.
`default_nettype none

module kcc_step (
  input  kcc_pkg::click_state_t cur,
  input  logic                  key_pressed,
  input  kcc_pkg::count_t       click_window,
  output kcc_pkg::click_state_t nxt,
  output kcc_pkg::click_kind_t  click_kind
);
  import kcc_pkg::*;

  count_t hold_n;
  count_t gap_inc;

  always_comb begin
    nxt        = cur;
    click_kind = KIND_NONE;
    hold_n     = key_pressed ? sat_inc(cur.hold_ticks) : '0;
    gap_inc    = sat_inc(cur.gap_ticks);

    nxt.hold_ticks  = hold_n;
    nxt.press_latch = cur.press_latch | key_pressed;

    // count a new press once
    if (!cur.edge_taken) begin
      if (nxt.press_latch) begin
        if (cur.pending_clicks != 2'd3) begin
          nxt.pending_clicks = cur.pending_clicks + 2'd1;
        end
        nxt.edge_taken = 1'b1;
      end
      if (nxt.pending_clicks == 2'd2) begin
        nxt.pending_clicks = 2'd0;
        nxt.gap_ticks      = '0;
        click_kind         = KIND_DOUBLE;
      end
    end

    if (click_kind != KIND_DOUBLE) begin
      if (!key_pressed) begin
        nxt.press_latch = 1'b0;
        nxt.edge_taken  = 1'b0;
      end
      if (nxt.pending_clicks == 2'd1) begin
        nxt.gap_ticks = gap_inc;
        if (gap_inc > click_window && hold_n < click_window) begin
          nxt.pending_clicks = 2'd0;
          nxt.gap_ticks      = '0;
          click_kind         = KIND_SINGLE;
        end else if (hold_n > click_window) begin
          // long hold cancels the pending click
          nxt.pending_clicks = 2'd0;
          nxt.gap_ticks      = '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/key_click_classifier_top.sv -----
// Top level of the single/double click classifier for one push-button.
//
// Usage:
//   in_ch  : one button sample per timer tick (key_pressed, 1 = pressed).
//   out_ch : one click_kind per accepted sample: none, single or double.
//   cfg_*  : cfg_we writes cfg_wdata into click_window (reset 100 ticks),
//            the single-click timeout and long-hold limit. Write while idle.
// Result: the result of a sample is registered and valid the cycle after it is accepted.
// Throughput: one item per cycle unless a held result stalls in_ch; the state update is a single combinational
//   pass (saturating adds and window compares) from the state registers to
//   the state and result registers.
// Stall: the result register holds while out_ch.ready is low; a new sample
//   is taken in the same cycle the held result leaves, so in_ch.ready is
//   low only while a result is held and not being taken.
// Reset (rst_n low, synchronous): all state cleared, no result pending,
//   click_window back to 100.
`default_nettype none

module key_click_classifier_top (
  input  logic                  clk,
  input  logic                  rst_n,
  kcc_in_if.sink                in_ch,
  kcc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  kcc_pkg::count_t       cfg_wdata
);
  import kcc_pkg::*;

  click_state_t state_r;
  click_state_t state_nxt;
  click_kind_t  kind_nxt;
  click_kind_t  kind_r;
  logic         out_valid_r;
  count_t       window_r;
  logic         in_fire;

  // take a sample whenever the result slot is free or being emptied
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  kcc_step u_step (
    .cur          (state_r),
    .key_pressed  (in_ch.key_pressed),
    .click_window (window_r),
    .nxt          (state_nxt),
    .click_kind   (kind_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      window_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= kind_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.click_kind = kind_r;

  // pending count never rests at two or more
  a_pending_low: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pending_clicks == 2'd0 || state_r.pending_clicks == 2'd1)
    else $error("pending click count out of range");

  // gap counter idles at zero with nothing pending
  a_gap_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pending_clicks == 2'd0 |-> state_r.gap_ticks == '0)
    else $error("gap counter running with no pending click");

  // a released sample clears the hold counter
  a_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_ch.key_pressed |=> state_r.hold_ticks == '0)
    else $error("hold counter not cleared on release");

  // a reported click leaves nothing pending
  a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r != KIND_NONE |-> state_r.pending_clicks == 2'd0)
    else $error("click reported while still pending");

endmodule

`default_nettype wire
